[rtl/pinrc_pkg.sv]
// Shared types and constants for the pin reference-count table.
`default_nettype none
package pinrc_pkg;

  localparam int unsigned PIN_ENTRIES_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF   = 48;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  localparam int unsigned OBJ_ADDR_W = 48;
  localparam int unsigned NEST_W     = 16;

  localparam logic [1:0] OP_PIN   = 2'd0;
  localparam logic [1:0] OP_UNPIN = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [OBJ_ADDR_W-1:0] object_address;
  } pin_req_t;

  typedef struct packed {
    logic              success;
    logic              pinned_now;
    logic [NEST_W-1:0] nest_count;
  } pin_rsp_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic       cmp_en;
    logic       upd_en;
    logic [1:0] op;
    logic       any_hit;
  } cell_ctrl_t;

  // Priority flags rippled from cell to cell, lowest entry first.
  typedef struct packed {
    logic hit_seen;
    logic free_seen;
  } cell_chain_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } seq_state_t;

endpackage
`default_nettype wire

[rtl/pinrc_cell.sv]
// One table entry: stored address, nesting count and its link in the priority chain.
`default_nettype none
module pinrc_cell
  import pinrc_pkg::*;
#(
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic [ADDR_BITS-1:0]  req_addr,
  input  wire cell_chain_t           chain_in,
  output cell_chain_t                chain_out,
  output logic [COUNT_BITS-1:0]      rpt_count,
  output logic                       rpt_sat
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic [ADDR_BITS-1:0]  addr_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  hit_r;
  logic                  free_r;

  logic                  hit_here;
  logic                  free_here;
  logic                  claim;
  logic                  sat_here;
  logic [COUNT_BITS-1:0] cnt_nxt;

  assign hit_here  = hit_r & ~chain_in.hit_seen;
  assign free_here = free_r & ~chain_in.free_seen;
  assign claim     = (ctrl.op == OP_PIN) & ~ctrl.any_hit & free_here;
  assign sat_here  = hit_here & (cnt_r == CNT_MAX);

  assign chain_out.hit_seen  = chain_in.hit_seen | hit_r;
  assign chain_out.free_seen = chain_in.free_seen | free_r;

  always_comb begin
    cnt_nxt = cnt_r;
    unique case (ctrl.op)
      OP_PIN: begin
        if (hit_here) begin
          cnt_nxt = sat_here ? cnt_r : cnt_r + CNT_ONE;
        end else if (claim) begin
          cnt_nxt = CNT_ONE;
        end
      end
      OP_UNPIN: begin
        if (hit_here) begin
          cnt_nxt = cnt_r - CNT_ONE;
        end
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  assign rpt_count = (hit_here | claim) ? cnt_nxt : '0;
  assign rpt_sat   = sat_here;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      cnt_r  <= '0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else begin
      if (ctrl.cmp_en) begin
        hit_r  <= (cnt_r != '0) && (addr_r == req_addr);
        free_r <= (cnt_r == '0);
      end
      if (ctrl.upd_en) begin
        cnt_r <= cnt_nxt;
        if (claim) begin
          addr_r <= req_addr;
        end else if (hit_here && (ctrl.op == OP_UNPIN) && (cnt_nxt == '0)) begin
          addr_r <= '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/pin_refcount_table.sv]
// Top level of the pin reference-count table: sequencer, cell chain and result register.
`default_nettype none
// Associative table of PIN_ENTRIES pinned object addresses, each with a
// nesting count. A transaction carries an opcode (pin, unpin, query) and an
// address; each yields exactly one result transaction. Pin on a held address
// bumps its count (saturating, flagged as failure); otherwise it claims the
// lowest free entry with count one, or fails when the table is full. Unpin
// drops the count and frees the entry at zero. Query reports presence and
// count. A null address changes nothing and reports all zeros. An item is
// handled in a match state, in which every cell compares its stored address
// with the request, then an update state, in which the lowest hit or free
// entry is picked along the cell chain and updated. The next item is taken
// in the cycle the current one commits, so items do not overlap; a stalled
// result holds the update step until the output register frees up. Reset
// clears every entry at once; there is no clearing pass.
module pin_refcount_table
  import pinrc_pkg::*;
#(
  parameter int unsigned PIN_ENTRIES = PIN_ENTRIES_DEF,
  parameter int unsigned ADDR_BITS   = ADDR_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire pin_req_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pin_rsp_t      out_data
);

  // Widths for clamping the count to the 16-bit result field.
  localparam int unsigned EXT_W = (COUNT_BITS > NEST_W) ? COUNT_BITS : NEST_W;
  localparam logic [EXT_W-1:0] NEST_MAX_EXT = EXT_W'({NEST_W{1'b1}});

  seq_state_t state_r, state_nxt;

  // Captured request
  logic [1:0]           op_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [ADDR_BITS-1:0] in_addr;

  // Result register
  logic     out_valid_r, out_valid_nxt;
  pin_rsp_t out_data_r, rsp_nxt;

  logic       commit;
  logic       accept;
  logic       null_req;
  cell_ctrl_t ctrl;

  cell_chain_t           chain  [PIN_ENTRIES+1];
  logic [COUNT_BITS-1:0] rpt_cnt [PIN_ENTRIES];
  logic                  rpt_sat [PIN_ENTRIES];
  logic [COUNT_BITS-1:0] cnt_all;
  logic                  sat_any;
  logic                  any_hit;
  logic                  any_free;
  logic [EXT_W-1:0]      cnt_ext;

  assign in_addr  = ADDR_BITS'(in_data.object_address);
  assign null_req = (addr_r == '0);
  assign accept   = in_valid & ~in_stall;

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   state_nxt = in_valid ? S_MATCH : S_IDLE;
      S_MATCH:  state_nxt = S_UPDATE;
      S_UPDATE: begin
        if (commit) begin
          state_nxt = in_valid ? S_MATCH : S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    commit   = 1'b0;
    in_stall = 1'b1;
    ctrl     = '0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_MATCH: begin
        ctrl.cmp_en = 1'b1;
      end
      S_UPDATE: begin
        commit      = ~out_valid_r | ~out_stall;
        in_stall    = ~commit;
        ctrl.upd_en = commit & ~null_req;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    ctrl.op      = op_r;
    ctrl.any_hit = any_hit;
  end

  // ---------------- cell chain ----------------
  assign chain[0] = '0;

  for (genvar g = 0; g < PIN_ENTRIES; g++) begin : g_cell
    pinrc_cell #(
      .ADDR_BITS  (ADDR_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .req_addr  (addr_r),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .rpt_count (rpt_cnt[g]),
      .rpt_sat   (rpt_sat[g])
    );
  end

  assign any_hit  = chain[PIN_ENTRIES].hit_seen;
  assign any_free = chain[PIN_ENTRIES].free_seen;

  // At most one cell reports, so an OR gathers its count.
  always_comb begin
    cnt_all = '0;
    sat_any = 1'b0;
    for (int i = 0; i < PIN_ENTRIES; i++) begin
      cnt_all = cnt_all | rpt_cnt[i];
      sat_any = sat_any | rpt_sat[i];
    end
  end

  assign cnt_ext = EXT_W'(cnt_all);

  // ---------------- result assembly ----------------
  always_comb begin
    rsp_nxt            = '0;
    rsp_nxt.pinned_now = (cnt_all != '0);
    rsp_nxt.nest_count = (cnt_ext > NEST_MAX_EXT) ? {NEST_W{1'b1}} : cnt_ext[NEST_W-1:0];
    unique case (op_r)
      OP_PIN:   rsp_nxt.success = any_hit ? ~sat_any : any_free;
      OP_UNPIN: rsp_nxt.success = any_hit;
      OP_QUERY: rsp_nxt.success = 1'b1;
      default:  rsp_nxt.success = 1'b0;
    endcase
    if (null_req) begin
      rsp_nxt = '0;
    end
  end

  assign out_valid_nxt = commit | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_data.opcode;
      addr_r <= in_addr;
    end
    if (commit) begin
      out_data_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[verif/tb_pin_refcount_table.sv]
// Self-checking testbench for the pin reference-count table.
`timescale 1ns / 1ps

module tb_pin_refcount_table
  import pinrc_pkg::*;
;

  // Opcode 3 has no package name; the block must treat it as a query that fails.
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int unsigned ENTRIES      = PIN_ENTRIES_DEF;
  localparam int unsigned POOL_SIZE    = 24;   // a bit more than the table, so it fills
  localparam int unsigned FILL_COUNT   = 15;   // one entry is already held when the fill starts
  localparam int unsigned RAND_ITEMS   = 1920;
  localparam int unsigned HOLD_AT      = 600;  // random transaction index that starts the hold-off
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned ERR_PRINT_CAP = 200;

  localparam logic [OBJ_ADDR_W-1:0] ADDR_TOP = '1;
  localparam logic [NEST_W-1:0]     NEST_TOP = '1;

  // ---------------------------------------------------------------------------
  // Clock, reset and block I/O. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  pin_req_t in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  pin_rsp_t out_data;

  pin_refcount_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow table. An entry is live exactly when its count is nonzero; the
  // lowest live match wins, and a new pin claims the lowest free slot.
  // ---------------------------------------------------------------------------
  logic [OBJ_ADDR_W-1:0] shadow_addr [ENTRIES];
  logic [NEST_W-1:0]     shadow_nest [ENTRIES];

  pin_rsp_t rsp_q[$];     // responses owed by the block, oldest first
  int unsigned fail_count = 0;
  bit idle_on = 1'b1;     // random gaps on both channels
  bit hold_go = 1'b0;     // asks the response side for one long hold-off

  function automatic pin_rsp_t pin_table_step(input pin_req_t req);
    pin_rsp_t rsp;
    int hit;
    int free_slot;
    rsp = '0;
    hit = -1;
    free_slot = -1;
    // Null address: nothing changes, all-zero response for every opcode.
    if (req.object_address == '0) return rsp;
    // Scan from the top down so the lowest index is what remains.
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (shadow_nest[i] != '0 && shadow_addr[i] == req.object_address) hit = i;
      if (shadow_nest[i] == '0) free_slot = i;
    end
    case (req.opcode)
      OP_PIN: begin
        if (hit >= 0) begin
          // Saturated count stays put and reports failure.
          if (shadow_nest[hit] != NEST_TOP) begin
            shadow_nest[hit] = shadow_nest[hit] + 1'b1;
            rsp.success = 1'b1;
          end
        end else if (free_slot >= 0) begin
          shadow_addr[free_slot] = req.object_address;
          shadow_nest[free_slot] = NEST_W'(1);
          hit = free_slot;
          rsp.success = 1'b1;
        end
        // else: table full, all zeros
      end
      OP_UNPIN: begin
        if (hit >= 0) begin
          shadow_nest[hit] = shadow_nest[hit] - 1'b1;
          if (shadow_nest[hit] == '0) shadow_addr[hit] = '0;
          rsp.success = 1'b1;
        end
      end
      default: begin
        // Query succeeds; the spare opcode reports the same but fails.
        rsp.success = (req.opcode == OP_QUERY);
      end
    endcase
    if (hit >= 0) begin
      rsp.nest_count = shadow_nest[hit];
      rsp.pinned_now = (shadow_nest[hit] != '0);
    end
    return rsp;
  endfunction

  // Mostly zero or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [OBJ_ADDR_W-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[OBJ_ADDR_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Payload and valid change only at a rising edge; valid stays
  // high straight into the next transaction when there is no gap.
  // ---------------------------------------------------------------------------
  task automatic send_req(input pin_req_t req, input bit typed, input pin_rsp_t typed_rsp);
    int unsigned gap;
    pin_rsp_t pred;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    // Accepted at this edge. The shadow table always advances; directed rows
    // with a hand-written response check against that instead.
    pred = pin_table_step(req);
    rsp_q.push_back(typed ? typed_rsp : pred);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: compare each accepted transaction, then choose next stall.
  // ---------------------------------------------------------------------------
  task automatic flag_field(input string name, input longint unsigned exp_v,
                            input longint unsigned act_v);
    fail_count++;
    if (fail_count <= ERR_PRINT_CAP)
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
  endtask

  initial begin : rsp_side
    pin_rsp_t want;
    int unsigned quiet_left;
    int unsigned stall_left;
    int unsigned hold_left;
    quiet_left = 0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
        if (rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= ERR_PRINT_CAP)
            $error("response with no request pending: %p", out_data);
        end else begin
          want = rsp_q.pop_front();
          if (out_data.success !== want.success)
            flag_field("success", want.success, out_data.success);
          if (out_data.pinned_now !== want.pinned_now)
            flag_field("pinned_now", want.pinned_now, out_data.pinned_now);
          if (out_data.nest_count !== want.nest_count)
            flag_field("nest_count", want.nest_count, out_data.nest_count);
        end
      end
      // Long hold-off: the request side keeps offering until the block backs up.
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (!idle_on) begin
        out_stall <= 1'b0;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        quiet_left = $urandom_range(0, 12);
        stall_left = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pin_refcount_table: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  typedef struct {
    pin_req_t req;
    bit       typed;
    pin_rsp_t rsp;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(input logic [1:0] op, input logic [OBJ_ADDR_W-1:0] addr,
                                  input bit typed, input logic ok, input logic held,
                                  input logic [NEST_W-1:0] cnt);
    dir_row_t row;
    row.req.opcode         = op;
    row.req.object_address = addr;
    row.typed              = typed;
    row.rsp.success        = ok;
    row.rsp.pinned_now     = held;
    row.rsp.nest_count     = cnt;
    dir_rows.push_back(row);
  endfunction

  initial begin : stim
    logic [OBJ_ADDR_W-1:0] pool [POOL_SIZE];
    logic [OBJ_ADDR_W-1:0] a;
    logic [1:0] op;
    pin_req_t req;
    int unsigned pick;

    for (int i = 0; i < ENTRIES; i++) begin
      shadow_addr[i] = '0;
      shadow_nest[i] = '0;
    end

    // Address pool: random bases plus near-misses one bit away from a base.
    for (int i = 0; i < FILL_COUNT; i++) begin
      pool[i] = rand_addr();
      if (pool[i] == '0) pool[i] = 48'h0000_0000_1001;
    end
    for (int i = FILL_COUNT; i < POOL_SIZE; i++) begin
      pool[i] = pool[$urandom_range(0, FILL_COUNT - 1)] ^ (48'd1 << $urandom_range(0, 47));
      if (pool[i] == '0) pool[i] = 48'h8000_0000_0001;
    end

    // Null address with every opcode, then absent-address cases.
    add_row(OP_QUERY, '0,       1, 0, 0, 0);
    add_row(OP_PIN,   '0,       1, 0, 0, 0);
    add_row(OP_UNPIN, '0,       1, 0, 0, 0);
    add_row(OP_SPARE, '0,       1, 0, 0, 0);
    add_row(OP_QUERY, 48'd1,    1, 1, 0, 0);
    add_row(OP_UNPIN, 48'd1,    1, 0, 0, 0);
    // Nesting on the all-ones address; the spare opcode reports but fails.
    add_row(OP_PIN,   ADDR_TOP, 1, 1, 1, 1);
    add_row(OP_PIN,   ADDR_TOP, 1, 1, 1, 2);
    add_row(OP_QUERY, ADDR_TOP, 1, 1, 1, 2);
    add_row(OP_SPARE, ADDR_TOP, 1, 0, 1, 2);
    add_row(OP_UNPIN, ADDR_TOP, 1, 1, 1, 1);
    // Fill the remaining entries, then a pin that finds the table full.
    for (int i = 0; i < FILL_COUNT; i++) add_row(OP_PIN, pool[i], 0, 0, 0, 0);
    add_row(OP_PIN, pool[FILL_COUNT], 1, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    // Random mix over the pool, so pins and unpins nest, free and refill the
    // table; a share of wide random addresses, nulls and the extremes.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == HOLD_AT) hold_go = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 78)      a = pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 88) a = rand_addr();
      else if (pick < 93) a = '0;
      else if (pick < 97) a = ADDR_TOP;
      else                a = 48'd1;
      pick = $urandom_range(0, 99);
      if (pick < 42)      op = OP_PIN;
      else if (pick < 82) op = OP_UNPIN;
      else if (pick < 95) op = OP_QUERY;
      else                op = OP_SPARE;
      req.opcode         = op;
      req.object_address = a;
      send_req(req, 0, '0);
    end
    in_valid <= 1'b0;

    while (rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("pin_refcount_table: match");
    end else begin
      $display("pin_refcount_table: mismatch");
    end
    $finish;
  end

endmodule
